// ===== src/dofg_pkg.sv =====
// Shared types and constants for the drop-oldest audio frame FIFO with gain.
// Holds the transaction structs, control structs and state encodings.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dofg_pkg;

  // Queue geometry. MAX_FRAMES must be a power of two so pointers wrap naturally.
  localparam int MAX_FRAMES   = 1024;
  localparam int MAX_CHANNELS = 8;
  localparam int PTR_W        = $clog2(MAX_FRAMES);
  localparam int CNT_W        = $clog2(MAX_FRAMES + 1);
  localparam int CHAN_W       = 4;

  // Sample and gain datapath widths.
  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = 17;
  localparam int UNITY_GAIN = 65536;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = (SAMPLE_W + 1) + (GAIN_W + 1);

  // Register map, indexed by paddr[3:2].
  localparam logic [1:0] REG_CHANNEL_COUNT   = 2'd0;
  localparam logic [1:0] REG_SAMPLE_KIND     = 2'd1;
  localparam logic [1:0] REG_VOLUME_GAIN     = 2'd2;
  localparam logic [1:0] REG_CAPACITY_FRAMES = 2'd3;

  typedef enum logic [1:0] {
    KIND_S16 = 2'd0,
    KIND_S32 = 2'd1,
    KIND_U8  = 2'd2,
    KIND_RAW = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_MUL  = 2'd2
  } state_e;

  // Input transaction: one command with a whole frame of lanes.
  typedef struct packed {
    logic               command;
    logic signed [31:0] lane0;
    logic signed [31:0] lane1;
    logic signed [31:0] lane2;
    logic signed [31:0] lane3;
    logic signed [31:0] lane4;
    logic signed [31:0] lane5;
    logic signed [31:0] lane6;
    logic signed [31:0] lane7;
  } in_item_t;

  // Result transaction of a pull.
  typedef struct packed {
    logic signed [31:0] out0;
    logic signed [31:0] out1;
    logic signed [31:0] out2;
    logic signed [31:0] out3;
    logic signed [31:0] out4;
    logic signed [31:0] out5;
    logic signed [31:0] out6;
    logic signed [31:0] out7;
    logic               underrun;
    logic [10:0]        frames_queued;
    logic [31:0]        frames_dropped;
  } out_item_t;

  // Memory and pipeline strobes from the queue controller to the lanes.
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             prod_load;
    logic             out_load;
  } mem_ctl_t;

  // Gain settings shared by all lanes.
  typedef struct packed {
    kind_e             kind;
    logic [GAIN_W-1:0] gain;
    logic              unity;
    logic              zero_gain;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== src/dofg_lane.sv =====
// One channel lane: frame storage for its channel plus the Q16 gain datapath.
// Read, multiply and finish each take one registered stage.
// Depends on dofg_pkg.
`default_nettype none

module dofg_lane
  import dofg_pkg::*;
(
  input  wire logic                clk,
  input  wire mem_ctl_t            mem_ctl,
  input  wire logic [SAMPLE_W-1:0] wr_data,
  input  wire lane_ctl_t           lane_ctl,
  input  wire logic                active,
  output logic [SAMPLE_W-1:0]      sample
);

  logic [SAMPLE_W-1:0]      mem [MAX_FRAMES];
  logic [SAMPLE_W-1:0]      rdata_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [SAMPLE_W-1:0]      sample_r;
  logic [SAMPLE_W-1:0]      sample_nxt;
  logic signed [SAMPLE_W:0] x;
  logic signed [GAIN_W:0]   gm;
  logic [SAMPLE_W-1:0]      pass;
  logic [PROD_W-FRAC_W-1:0] q_floor;
  logic [PROD_W-FRAC_W-1:0] q_trunc;
  logic                     round_up;

  // Channel storage: one write port for pushes, one registered read port for pulls.
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[mem_ctl.wr_addr] <= wr_data;
    end
    if (mem_ctl.rd_en) begin
      rdata_r <= mem[mem_ctl.rd_addr];
    end
  end

  // Sign the stored word according to the sample kind.
  always_comb begin
    case (lane_ctl.kind)
      KIND_S16: x = {{(SAMPLE_W - 15){rdata_r[15]}}, rdata_r[15:0]};
      KIND_S32: x = {rdata_r[SAMPLE_W-1], rdata_r};
      KIND_U8:  x = $signed({{(SAMPLE_W - 7){1'b0}}, rdata_r[7:0]}) - 33'sd128;
      default:  x = {rdata_r[SAMPLE_W-1], rdata_r};
    endcase
  end

  // Unity-gain value of the sample, as the output presents it.
  always_comb begin
    case (lane_ctl.kind)
      KIND_S16: pass = x[SAMPLE_W-1:0];
      KIND_U8:  pass = {{(SAMPLE_W - 8){1'b0}}, rdata_r[7:0]};
      default:  pass = rdata_r;
    endcase
  end

  // Multiply stage: a 33 by 18 signed product.
  assign gm       = {1'b0, lane_ctl.gain};
  assign prod_nxt = x * gm;

  always_ff @(posedge clk) begin
    if (mem_ctl.prod_load) begin
      prod_r <= prod_nxt;
    end
  end

  // Finish stage. Below unity the magnitude never grows, so the results already
  // lie in each kind's range. Signed kinds round toward zero, 8-bit rounds down.
  assign q_floor  = prod_r[PROD_W-1:FRAC_W];
  assign round_up = prod_r[PROD_W-1] && (|prod_r[FRAC_W-1:0]);
  assign q_trunc  = q_floor + (PROD_W - FRAC_W)'(round_up);

  always_comb begin
    if (!active || lane_ctl.zero_gain) begin
      sample_nxt = '0;
    end else if (lane_ctl.kind == KIND_RAW) begin
      sample_nxt = rdata_r;
    end else if (lane_ctl.unity) begin
      sample_nxt = pass;
    end else begin
      case (lane_ctl.kind)
        KIND_U8: sample_nxt = q_floor[SAMPLE_W-1:0] + 32'd128;
        default: sample_nxt = q_trunc[SAMPLE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.out_load) begin
      sample_r <= sample_nxt;
    end
  end

  assign sample = sample_r;

endmodule

`default_nettype wire

// ===== src/dofg_queue.sv =====
// Queue controller: read and write pointers, fill and drop counters, and the
// pull sequencer that steps the lanes through read, multiply and finish.
// Depends on dofg_pkg.
`default_nettype none

module dofg_queue
  import dofg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             command,
  input  wire logic [10:0]      capacity,
  output logic                  busy,
  output mem_ctl_t              mem_ctl,
  output logic                  empty,
  output logic                  out_valid,
  output logic [10:0]           frames_queued,
  output logic [31:0]           frames_dropped
);

  state_e           state_r;
  state_e           state_nxt;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W-1:0] rp_nxt;
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] wp_nxt;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [31:0]      dropped_r;
  logic [31:0]      dropped_nxt;
  logic             empty_r;
  logic [10:0]      queued_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] n_drop;
  logic             accept;
  logic             push;
  logic             pull;
  logic             full;

  // Effective capacity: zero acts as one, values above the store act as the store size.
  always_comb begin
    if (capacity == 11'd0) begin
      cap_eff = CNT_W'(1);
    end else if (CNT_W'(capacity) > CNT_W'(MAX_FRAMES)) begin
      cap_eff = CNT_W'(MAX_FRAMES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign accept = start && (state_r == ST_IDLE);
  assign push   = accept && !command;
  assign pull   = accept && command;
  assign full   = fill_r >= cap_eff;
  assign n_drop = fill_r + CNT_W'(1) - cap_eff;

  // Next state and strobes of the pull sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (pull) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy              = (state_r != ST_IDLE);
  assign mem_ctl.wr_en     = push;
  assign mem_ctl.wr_addr   = wp_r;
  assign mem_ctl.rd_en     = pull;
  assign mem_ctl.rd_addr   = rp_r;
  assign mem_ctl.prod_load = (state_r == ST_READ);
  assign mem_ctl.out_load  = (state_r == ST_MUL);

  // Pointer and counter updates. A push into a full queue drops the oldest frames.
  always_comb begin
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    if (push) begin
      wp_nxt = wp_r + PTR_W'(1);
      if (full) begin
        rp_nxt      = rp_r + n_drop[PTR_W-1:0];
        fill_nxt    = cap_eff;
        dropped_nxt = dropped_r + 32'(n_drop);
      end else begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end else if (pull && (fill_r != '0)) begin
      rp_nxt   = rp_r + PTR_W'(1);
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      dropped_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= (state_r == ST_MUL);
    end
  end

  // Status of the pull transaction, captured when it is accepted.
  always_ff @(posedge clk) begin
    if (pull) begin
      empty_r  <= (fill_r == '0);
      queued_r <= 11'(fill_nxt);
    end
  end

  assign empty          = empty_r;
  assign out_valid      = out_valid_r;
  assign frames_queued  = queued_r;
  assign frames_dropped = dropped_r;

  // The pointer distance always matches the fill count.
  a_ptr_fill : assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wp_r - rp_r) == fill_r[PTR_W-1:0])
    else $error("pointer distance disagrees with fill count");

  // The fill count never exceeds the store.
  a_fill_max : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_FRAMES))
    else $error("fill count beyond store size");

  // A push into a full queue leaves it at capacity and counts every dropped frame.
  a_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |=>
      (fill_r == $past(cap_eff)) && (dropped_r == $past(dropped_r + 32'(n_drop))))
    else $error("drop-oldest accounting wrong");

  // A pull always produces its result strobe once the sequencer has passed READ and MUL.
  a_pull_result : assert property (@(posedge clk) disable iff (!rst_n)
    pull |-> ##3 out_valid_r)
    else $error("pull without result");

endmodule

`default_nettype wire

// ===== src/drop_oldest_audio_frame_fifo_with_gain_top.sv =====
// Pull: accepted only while idle; busy is high through the READ and MUL states, and the
// result and its strobe come from the memory read, multiply and finish stages in the lanes.
// Push: back to back while idle; the frame is written to all eight lane memories at once.
// The receiver cannot stall; each result is on out_data for the one strobe cycle.
// Synchronous active-low reset empties the queue, clears the drop count and loads
// register defaults; the frame store itself is not cleared and needs no clearing pass.
`default_nettype none

module drop_oldest_audio_frame_fifo_with_gain_top
  import dofg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_strobe,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CHAN_W-1:0]   channel_count_r;
  logic [1:0]          sample_kind_r;
  logic [GAIN_W-1:0]   volume_gain_r;
  logic [10:0]         capacity_frames_r;
  logic                cfg_write;
  logic [CHAN_W-1:0]   cc_eff;
  lane_ctl_t           lane_ctl;
  mem_ctl_t            mem_ctl;
  logic                empty;
  logic [10:0]         frames_queued;
  logic [31:0]         frames_dropped;
  logic [SAMPLE_W-1:0] lane_in  [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] lane_out [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] active;

  // Configuration registers on the APB-style port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r   <= CHAN_W'(2);
      sample_kind_r     <= KIND_S16;
      volume_gain_r     <= GAIN_W'(UNITY_GAIN);
      capacity_frames_r <= 11'd960;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_CHANNEL_COUNT:   channel_count_r   <= pwdata[CHAN_W-1:0];
        REG_SAMPLE_KIND:     sample_kind_r     <= pwdata[1:0];
        REG_VOLUME_GAIN:     volume_gain_r     <= pwdata[GAIN_W-1:0];
        REG_CAPACITY_FRAMES: capacity_frames_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNEL_COUNT:   prdata = 32'(channel_count_r);
      REG_SAMPLE_KIND:     prdata = 32'(sample_kind_r);
      REG_VOLUME_GAIN:     prdata = 32'(volume_gain_r);
      REG_CAPACITY_FRAMES: prdata = 32'(capacity_frames_r);
      default:             prdata = '0;
    endcase
  end

  // Gain settings shared by the lanes; gains above unity act as unity.
  always_comb begin
    lane_ctl.kind = kind_e'(sample_kind_r);
    if (volume_gain_r > GAIN_W'(UNITY_GAIN)) begin
      lane_ctl.gain = GAIN_W'(UNITY_GAIN);
    end else begin
      lane_ctl.gain = volume_gain_r;
    end
    lane_ctl.unity     = (lane_ctl.gain == GAIN_W'(UNITY_GAIN));
    lane_ctl.zero_gain = (lane_ctl.gain == '0);
  end

  // Effective channel count: zero acts as one, above the lane count acts as all lanes.
  always_comb begin
    if (channel_count_r == '0) begin
      cc_eff = CHAN_W'(1);
    end else if (channel_count_r > CHAN_W'(MAX_CHANNELS)) begin
      cc_eff = CHAN_W'(MAX_CHANNELS);
    end else begin
      cc_eff = channel_count_r;
    end
  end

  // Queue controller.
  dofg_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .command        (in_data.command),
    .capacity       (capacity_frames_r),
    .busy           (busy),
    .mem_ctl        (mem_ctl),
    .empty          (empty),
    .out_valid      (out_strobe),
    .frames_queued  (frames_queued),
    .frames_dropped (frames_dropped)
  );

  // Split the incoming frame across the lanes.
  assign lane_in[0] = in_data.lane0;
  assign lane_in[1] = in_data.lane1;
  assign lane_in[2] = in_data.lane2;
  assign lane_in[3] = in_data.lane3;
  assign lane_in[4] = in_data.lane4;
  assign lane_in[5] = in_data.lane5;
  assign lane_in[6] = in_data.lane6;
  assign lane_in[7] = in_data.lane7;

  // Eight lanes working side by side on one frame.
  for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_lane
    assign active[j] = !empty && (CHAN_W'(j) < cc_eff);

    dofg_lane u_lane (
      .clk      (clk),
      .mem_ctl  (mem_ctl),
      .wr_data  (lane_in[j]),
      .lane_ctl (lane_ctl),
      .active   (active[j]),
      .sample   (lane_out[j])
    );
  end

  // Merge the lane results with the queue status into one result transaction.
  assign out_data.out0           = lane_out[0];
  assign out_data.out1           = lane_out[1];
  assign out_data.out2           = lane_out[2];
  assign out_data.out3           = lane_out[3];
  assign out_data.out4           = lane_out[4];
  assign out_data.out5           = lane_out[5];
  assign out_data.out6           = lane_out[6];
  assign out_data.out7           = lane_out[7];
  assign out_data.underrun       = empty;
  assign out_data.frames_queued  = frames_queued;
  assign out_data.frames_dropped = frames_dropped;

endmodule

`default_nettype wire
